>>> hw/rtl/pip_pkg.sv
// Shared types and constants for the point-in-polygon test block.
// No dependencies; used by pip_vstore, pip_edge and point_in_polygon_test.
package pip_pkg;

	localparam int COORD_W          = 32;
	localparam int DIFF_W           = COORD_W + 1;
	localparam int PROD_W           = 2 * DIFF_W;
	localparam int CNT_W            = 7;
	localparam int IDX_W            = 6;
	localparam int MAX_VERTICES_DEF = 64;
	localparam int MIN_CLOSE_CNT    = 4;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} vertex_t;

	// one edge (vi -> vj) to be checked against the point pt
	typedef struct packed {
		logic    vld;
		vertex_t vi;
		vertex_t vj;
		vertex_t pt;
	} edge_req_t;

	typedef struct packed {
		logic busy;
		logic flip;
	} edge_stat_t;

endpackage

>>> hw/rtl/pip_vstore.sv
// Vertex store: one write port, one read port, registered read data.
// Depends on pip_pkg for the vertex type.
module pip_vstore #(
	parameter int DEPTH = pip_pkg::MAX_VERTICES_DEF
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  pip_pkg::vertex_t           wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output pip_pkg::vertex_t           rdata
);

	pip_pkg::vertex_t mem [DEPTH];
	pip_pkg::vertex_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/pip_edge.sv
// Edge crossing evaluator: two-stage pipeline, differences then exact products.
// Depends on pip_pkg for widths and the edge request/status structs.
module pip_edge (
	input  logic                clk,
	input  logic                arst_n,
	input  pip_pkg::edge_req_t  req,
	output pip_pkg::edge_stat_t stat
);

	logic signed [pip_pkg::DIFF_W-1:0] dx1, dx2, dy1, dy2;
	logic                              straddle, m1_neg, m2_neg, short_tog;

	logic                              v_s1, tog_s1, mul_s1, dy2neg_s1;
	logic signed [pip_pkg::DIFF_W-1:0] dx1_s1, dx2_s1, dy1_s1, dy2_s1;

	logic                              v_s2, tog_s2, mul_s2, dy2neg_s2;
	logic signed [pip_pkg::PROD_W-1:0] p1_s2, p2_s2;

	logic                              cmp_tog;

	always_comb begin
		dx1 = $signed({req.pt.x[pip_pkg::COORD_W-1], req.pt.x})
			- $signed({req.vi.x[pip_pkg::COORD_W-1], req.vi.x});
		dx2 = $signed({req.vj.x[pip_pkg::COORD_W-1], req.vj.x})
			- $signed({req.vi.x[pip_pkg::COORD_W-1], req.vi.x});
		dy1 = $signed({req.pt.y[pip_pkg::COORD_W-1], req.pt.y})
			- $signed({req.vi.y[pip_pkg::COORD_W-1], req.vi.y});
		dy2 = $signed({req.vj.y[pip_pkg::COORD_W-1], req.vj.y})
			- $signed({req.vi.y[pip_pkg::COORD_W-1], req.vi.y});
		straddle = ($signed(req.vi.y) > $signed(req.pt.y))
			!= ($signed(req.vj.y) > $signed(req.pt.y));
		// sign of each product, zero counts as positive
		m1_neg = dx1[pip_pkg::DIFF_W-1] ^ dy2[pip_pkg::DIFF_W-1];
		m2_neg = dx2[pip_pkg::DIFF_W-1] ^ dy1[pip_pkg::DIFF_W-1];
		if (dy2[pip_pkg::DIFF_W-1]) begin
			short_tog = !m1_neg && m2_neg;
		end else begin
			short_tog = m1_neg && !m2_neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= req.vld;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		tog_s1    <= straddle && short_tog;
		mul_s1    <= straddle && (m1_neg == m2_neg);
		dy2neg_s1 <= dy2[pip_pkg::DIFF_W-1];
		dx1_s1    <= dx1;
		dx2_s1    <= dx2;
		dy1_s1    <= dy1;
		dy2_s1    <= dy2;

		tog_s2    <= tog_s1;
		mul_s2    <= mul_s1;
		dy2neg_s2 <= dy2neg_s1;
		p1_s2     <= dx1_s1 * dy2_s1;
		p2_s2     <= dx2_s1 * dy1_s1;
	end

	always_comb begin
		if (dy2neg_s2) begin
			cmp_tog = p1_s2 > p2_s2;
		end else begin
			cmp_tog = p1_s2 < p2_s2;
		end
	end

	assign stat.busy = v_s1 || v_s2;
	assign stat.flip = v_s2 && (tog_s2 || (mul_s2 && cmp_tog));

endmodule

>>> hw/rtl/point_in_polygon_test.sv
// Top level of the point-in-polygon test: sequencer, count register, result register.
// Depends on pip_pkg, pip_vstore and pip_edge.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word: cmd, vertex_index, coord_x, coord_y.
//   A load word (cmd 0) writes vertex (coord_x, coord_y) into slot vertex_index and
//   produces no result; slots at or beyond MAX_VERTICES are dropped.
//   A test word (cmd 1) walks the closed fence of the first vertex_count vertices with
//   the crossing-number rule and returns one word on the output channel
//   (out_valid/out_ready): outside = 1 when the point lies outside.
//   vertex_count is to be written through cfg_we/cfg_wdata only while the block is idle;
//   the block does not enforce this. Values above MAX_VERTICES act as MAX_VERTICES.
//   With fewer than two vertices the answer is outside = 1, with no fence walk.
// Flow: one test at a time; the next word is taken only once the result has moved into
//   the output register. The single read port of the vertex store reads one vertex per
//   cycle, and one edge per cycle goes into a two-stage evaluator (33-bit differences,
//   then exact 66-bit cross products). On fences of four or more, a closing vertex that
//   repeats the first one is dropped from the walk.
// Reset: vertex_count clears to 0, no word is pending; the vertex store holds
//   nothing defined until loaded.
// Stall: the result sits in an output register; loads are still taken while it waits,
//   and a following test runs and holds its own result until the register frees up.
module point_in_polygon_test #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               cmd,
	input  logic [pip_pkg::IDX_W-1:0]          vertex_index,
	input  logic signed [pip_pkg::COORD_W-1:0] coord_x,
	input  logic signed [pip_pkg::COORD_W-1:0] coord_y,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               outside,
	input  logic                               cfg_we,
	input  logic [pip_pkg::CNT_W-1:0]          cfg_wdata
);

	localparam int AW = $clog2(MAX_VERTICES);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_RDLAST  = 8'b0000_0010,
		S_RDFIRST = 8'b0000_0100,
		S_CHECK   = 8'b0000_1000,
		S_WALK    = 8'b0001_0000,
		S_WRAP    = 8'b0010_0000,
		S_DRAIN   = 8'b0100_0000,
		S_PUT     = 8'b1000_0000
	} state_t;

	state_t                    state_q;
	logic [pip_pkg::CNT_W-1:0] vcount_q;
	logic [pip_pkg::CNT_W-1:0] n_q;
	logic [pip_pkg::CNT_W-1:0] n_eff;
	logic [AW-1:0]             ptr_q;
	logic [AW-1:0]             last_idx_q;
	pip_pkg::vertex_t          pt_q, first_q, lastv_q, prev_q;
	logic                      acc_q;
	logic                      out_valid_q, outside_q;

	logic                      in_acc, out_free, drop_last;
	logic                      wr_en, rd_en;
	logic [AW-1:0]             wr_addr, rd_addr;
	pip_pkg::vertex_t          wr_data, rd_data;
	pip_pkg::edge_req_t        ereq;
	pip_pkg::edge_stat_t       estat;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// clamp the fence size to the store capacity
	assign n_eff = (int'(vcount_q) > MAX_VERTICES) ? pip_pkg::CNT_W'(MAX_VERTICES) : vcount_q;

	// a closing vertex equal to the first is dropped on fences of four or more
	assign drop_last = (int'(n_q) >= pip_pkg::MIN_CLOSE_CNT) && (lastv_q == rd_data);

	// load path: write straight into the store on acceptance
	assign wr_en   = in_acc && (cmd == pip_pkg::CMD_LOAD) && (int'(vertex_index) < MAX_VERTICES);
	assign wr_addr = AW'(vertex_index);
	assign wr_data = '{x: coord_x, y: coord_y};

	// read address: last vertex, then vertex 0, then walk upward
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_RDLAST: begin
				rd_en   = 1'b1;
				rd_addr = AW'(n_q - pip_pkg::CNT_W'(1));
			end
			S_RDFIRST: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			S_CHECK: begin
				rd_en   = 1'b1;
				rd_addr = AW'(1);
			end
			S_WALK: begin
				rd_en   = (ptr_q != last_idx_q);
				rd_addr = ptr_q + AW'(1);
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	// edge feed: (prev, current) while walking, (last, first) to close the fence
	always_comb begin
		ereq.vld = 1'b0;
		ereq.vi  = prev_q;
		ereq.vj  = rd_data;
		ereq.pt  = pt_q;
		case (state_q)
			S_WALK: begin
				ereq.vld = 1'b1;
			end
			S_WRAP: begin
				ereq.vld = 1'b1;
				ereq.vj  = first_q;
			end
			default: begin
				ereq.vld = 1'b0;
			end
		endcase
	end

	pip_vstore #(
		.DEPTH(MAX_VERTICES)
	) u_vstore (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	pip_edge u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ereq),
		.stat   (estat)
	);

	// control: sequencer, count register, result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vcount_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			// raise the flag when a finished test moves into the output register,
			// drop it once the receiver takes the word
			if ((state_q == S_PUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && (cmd == pip_pkg::CMD_TEST)) begin
						state_q <= (int'(n_eff) < 2) ? S_PUT : S_RDLAST;
					end
				end
				S_RDLAST:  state_q <= S_RDFIRST;
				S_RDFIRST: state_q <= S_CHECK;
				S_CHECK:   state_q <= S_WALK;
				S_WALK: begin
					if (ptr_q == last_idx_q) begin
						state_q <= S_WRAP;
					end
				end
				S_WRAP:    state_q <= S_DRAIN;
				S_DRAIN: begin
					if (!estat.busy) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// start each test outside, then toggle on every crossing edge
		if ((state_q == S_IDLE) && in_acc) begin
			acc_q <= 1'b1;
		end else begin
			acc_q <= acc_q ^ estat.flip;
		end
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					pt_q <= '{x: coord_x, y: coord_y};
					n_q  <= n_eff;
				end
			end
			S_RDFIRST: begin
				lastv_q <= rd_data;
			end
			S_CHECK: begin
				first_q    <= rd_data;
				prev_q     <= rd_data;
				ptr_q      <= AW'(1);
				last_idx_q <= drop_last ? AW'(n_q - pip_pkg::CNT_W'(2))
					: AW'(n_q - pip_pkg::CNT_W'(1));
			end
			S_WALK: begin
				prev_q <= rd_data;
				ptr_q  <= ptr_q + AW'(1);
			end
			S_PUT: begin
				if (out_free) begin
					outside_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign outside   = outside_q;

endmodule

>>> sim/testbench.sv
// Self-checking testbench for point_in_polygon_test: vertex loads, point tests, fence sizes.
// Depends on pip_pkg and the point_in_polygon_test RTL (with pip_vstore and pip_edge).

class fence_checker;
	logic signed [pip_pkg::COORD_W-1:0] fence_x [pip_pkg::MAX_VERTICES_DEF];
	logic signed [pip_pkg::COORD_W-1:0] fence_y [pip_pkg::MAX_VERTICES_DEF];
	int unsigned fence_size;
	bit outside_due [$];
	int errors;
	int tests;
	int insides;

	function int side(longint v);
		return (v < 0) ? -1 : 1;
	endfunction

	// crossing-number walk over the closed fence, exact wide arithmetic throughout
	function bit crossing_outside(longint px, longint py);
		int unsigned n, i, j;
		bit flag;
		longint xi, yi, xj, yj, dx1, dx2, dy1, dy2;
		int m1, m2;
		logic signed [127:0] lhs, rhs;
		flag = 1'b1;
		n = (fence_size > pip_pkg::MAX_VERTICES_DEF) ? pip_pkg::MAX_VERTICES_DEF : fence_size;
		// drop a closing vertex that repeats the first one
		if (n >= pip_pkg::MIN_CLOSE_CNT && fence_x[n-1] == fence_x[0] &&
				fence_y[n-1] == fence_y[0])
			n--;
		for (i = 0; i < n; i++) begin
			j = (i + 1 >= n) ? 0 : i + 1;
			xi = longint'(fence_x[i]);
			yi = longint'(fence_y[i]);
			xj = longint'(fence_x[j]);
			yj = longint'(fence_y[j]);
			if ((yi > py) != (yj > py)) begin
				dx1 = px - xi;
				dx2 = xj - xi;
				dy1 = py - yi;
				dy2 = yj - yi;
				m1 = side(dx1) * side(dy2);
				m2 = side(dx2) * side(dy1);
				lhs = dx1;
				lhs = lhs * dy2;
				rhs = dx2;
				rhs = rhs * dy1;
				if (dy2 < 0) begin
					if (m1 > m2 || (m1 == m2 && lhs > rhs))
						flag = !flag;
				end else if (m1 < m2 || (m1 == m2 && lhs < rhs)) begin
					flag = !flag;
				end
			end
		end
		return flag;
	endfunction

	function void note_word(logic c, logic [pip_pkg::IDX_W-1:0] idx,
			logic signed [pip_pkg::COORD_W-1:0] x, logic signed [pip_pkg::COORD_W-1:0] y);
		if (c == pip_pkg::CMD_LOAD) begin
			if (idx < pip_pkg::MAX_VERTICES_DEF) begin
				fence_x[idx] = x;
				fence_y[idx] = y;
			end
		end else begin
			outside_due.push_back(crossing_outside(x, y));
			tests++;
		end
	endfunction

	function void check_outside(logic got);
		bit want;
		if (outside_due.size() == 0) begin
			$display("%0t: result outside=%b arrived with no test pending", $time, got);
			errors++;
		end else begin
			want = outside_due.pop_front();
			if (got !== want) begin
				$display("%0t: outside mismatch: expected %0b, actual %b", $time, want, got);
				errors++;
			end else if (!got) begin
				insides++;
			end
		end
	endfunction
endclass

module testbench;

	localparam int FENCE_CAP     = pip_pkg::MAX_VERTICES_DEF;
	// a test walks at most the whole fence plus the evaluator pipeline
	localparam int SETTLE_CYCLES = FENCE_CAP + 24;
	localparam int HOLD_CYCLES   = 400;
	localparam int TARGET_WORDS  = 1000;
	localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;

	// coordinate spread of a random fence
	typedef enum int {SPAN_TIGHT, SPAN_MID, SPAN_EDGE, SPAN_FULL} span_e;

	logic                               clk          = 1'b0;
	logic                               arst_n       = 1'b0;
	logic                               in_valid     = 1'b0;
	logic                               in_ready;
	logic                               cmd          = pip_pkg::CMD_LOAD;
	logic [pip_pkg::IDX_W-1:0]          vertex_index = '0;
	logic signed [pip_pkg::COORD_W-1:0] coord_x      = '0;
	logic signed [pip_pkg::COORD_W-1:0] coord_y      = '0;
	logic                               out_valid;
	logic                               out_ready    = 1'b0;
	logic                               outside;
	logic                               cfg_we       = 1'b0;
	logic [pip_pkg::CNT_W-1:0]          cfg_wdata    = '0;

	fence_checker board = new;

	int words_sent  = 0;
	int sizes_tried = 0;
	int burst_left  = 0;
	bit hold_req    = 1'b0;

	always #2 clk = ~clk;

	point_in_polygon_test DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.vertex_index (vertex_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.outside      (outside),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	// Offer one word and hold it until the handshake completes. The sender runs in
	// bursts; between bursts valid may drop for a random gap. Valid stays high from one
	// word to the next inside a burst.
	task automatic push_word(input logic c, input logic [pip_pkg::IDX_W-1:0] idx,
			input logic signed [31:0] x, input logic signed [31:0] y);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid     <= 1'b1;
		cmd          <= c;
		vertex_index <= idx;
		coord_x      <= x;
		coord_y      <= y;
		// sample in_ready as it stood just before each edge
		do @(posedge clk); while (!in_ready);
		board.note_word(c, idx, x, y);
		words_sent++;
	endtask

	// Drop valid, wait until every pending test has answered, then let the
	// pipeline run dry so the count register can be rewritten safely.
	task automatic settle();
		in_valid  <= 1'b0;
		burst_left = 0;
		while (board.outside_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_fence_size(input logic [pip_pkg::CNT_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		board.fence_size = int'(v);
		sizes_tried++;
	endtask

	function automatic logic signed [31:0] pick_coord(span_e span);
		case (span)
			SPAN_TIGHT: return $urandom_range(0, 40) - 20;
			SPAN_MID:   return $urandom_range(0, 2000000) - 1000000;
			SPAN_EDGE: begin
				case ($urandom_range(0, 5))
					0: return COORD_MIN;
					1: return COORD_MAX;
					2: return COORD_MIN + 1;
					3: return COORD_MAX - 1;
					default: return $urandom;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Aim test points at the interesting spots: vertices, their neighbors and
	// edge midpoints, where the exact comparison has to do the work.
	function automatic void pick_point(input int n, input span_e span,
			output logic signed [31:0] px, output logic signed [31:0] py);
		int k, m;
		longint sx, sy;
		k = (n > 0) ? $urandom_range(0, n - 1) : 0;
		m = (n > 0) ? $urandom_range(0, n - 1) : 0;
		if (n == 0 || $urandom_range(0, 7) == 0) begin
			px = pick_coord(($urandom_range(0, 7) == 0) ? SPAN_FULL : span);
			py = pick_coord(span);
			return;
		end
		case ($urandom_range(0, 5))
			0: begin
				px = board.fence_x[k];
				py = board.fence_y[k];
			end
			1: begin
				px = board.fence_x[k] + $urandom_range(0, 2) - 1;
				py = board.fence_y[k] + $urandom_range(0, 2) - 1;
			end
			2: begin
				m  = (k + 1 >= n) ? 0 : k + 1;
				sx = longint'(board.fence_x[k]) + longint'(board.fence_x[m]);
				sy = longint'(board.fence_y[k]) + longint'(board.fence_y[m]);
				px = 32'(sx >>> 1);
				py = 32'(sy >>> 1);
			end
			3: begin
				px = board.fence_x[k];
				py = board.fence_y[m];
			end
			default: begin
				px = pick_coord(span);
				py = pick_coord(span);
			end
		endcase
	endfunction

	// One random phase: pick a fence size, load every slot the walk will read,
	// then mostly point tests with a few vertex rewrites mixed in.
	task automatic random_phase(input bit squeeze);
		int r, size_cfg, n, tests, k;
		span_e span;
		bit closed;
		logic signed [31:0] px, py;
		r = $urandom_range(0, 99);
		if (squeeze)
			size_cfg = $urandom_range(3, 8);
		else if (r < 6)
			size_cfg = $urandom_range(0, 2);
		else if (r < 70)
			size_cfg = $urandom_range(3, 10);
		else if (r < 85)
			size_cfg = $urandom_range(11, 40);
		else if (r < 93)
			size_cfg = FENCE_CAP;
		else
			size_cfg = $urandom_range(FENCE_CAP + 1, (1 << pip_pkg::CNT_W) - 1);
		set_fence_size(pip_pkg::CNT_W'(size_cfg));
		n      = (size_cfg > FENCE_CAP) ? FENCE_CAP : size_cfg;
		span   = span_e'($urandom_range(0, 3));
		closed = (n >= pip_pkg::MIN_CLOSE_CNT) && ($urandom_range(0, 3) == 0);
		for (k = 0; k < n; k++) begin
			if (closed && k == n - 1)
				push_word(pip_pkg::CMD_LOAD, pip_pkg::IDX_W'(k),
					board.fence_x[0], board.fence_y[0]);
			else
				push_word(pip_pkg::CMD_LOAD, pip_pkg::IDX_W'(k),
					pick_coord(span), pick_coord(span));
		end
		// stray loads anywhere in the table
		repeat ($urandom_range(0, 2))
			push_word(pip_pkg::CMD_LOAD, pip_pkg::IDX_W'($urandom_range(0, FENCE_CAP - 1)),
				$urandom, $urandom);
		tests = squeeze ? 40 : ((n > 40) ? $urandom_range(4, 10) : $urandom_range(8, 30));
		if (squeeze)
			hold_req = 1'b1;
		repeat (tests) begin
			if ($urandom_range(0, 9) == 0) begin
				push_word(pip_pkg::CMD_LOAD,
					pip_pkg::IDX_W'((n > 0) ? $urandom_range(0, n - 1)
						: $urandom_range(0, FENCE_CAP - 1)),
					pick_coord(span), pick_coord(span));
			end else begin
				pick_point(n, span, px, py);
				push_word(pip_pkg::CMD_TEST,
					pip_pkg::IDX_W'($urandom_range(0, FENCE_CAP - 1)), px, py);
			end
		end
		settle();
	endtask

	// Receiver: check each accepted word, then pick out_ready for the next edge.
	// Modes change every so often: always ready, a rotating stall pattern, mostly
	// ready, mostly stalled. One long hold-off fills the block up on request.
	initial begin
		int mode, mode_left, hold_left;
		logic [7:0] pattern;
		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		pattern   = 8'h5b;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				board.check_outside(outside);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 160);
					pattern   = 8'($urandom_range(1, 255));
				end
				mode_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: begin
						out_ready <= pattern[0];
						pattern    = {pattern[0], pattern[7:1]};
					end
					2: out_ready <= ($urandom_range(0, 3) != 0);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		int phase_no;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		board.fence_size = 0;

		// Empty fence: every point is outside.
		set_fence_size(0);
		push_word(pip_pkg::CMD_TEST, 0, 0, 0);
		push_word(pip_pkg::CMD_TEST, '1, COORD_MIN, COORD_MAX);
		settle();

		// Square spanning the whole coordinate range; probe the center, a corner,
		// edges and a point just inside.
		set_fence_size(4);
		push_word(pip_pkg::CMD_LOAD, 0, COORD_MIN, COORD_MIN);
		push_word(pip_pkg::CMD_LOAD, 1, COORD_MAX, COORD_MIN);
		push_word(pip_pkg::CMD_LOAD, 2, COORD_MAX, COORD_MAX);
		push_word(pip_pkg::CMD_LOAD, 3, COORD_MIN, COORD_MAX);
		push_word(pip_pkg::CMD_TEST, 0, 0, 0);
		push_word(pip_pkg::CMD_TEST, 0, COORD_MIN, COORD_MIN);
		push_word(pip_pkg::CMD_TEST, 0, COORD_MAX, 0);
		push_word(pip_pkg::CMD_TEST, 0, 0, COORD_MAX);
		push_word(pip_pkg::CMD_TEST, 0, COORD_MIN + 1, COORD_MIN + 1);
		settle();

		// Fifth vertex repeats the first: it must be dropped from the walk.
		set_fence_size(5);
		push_word(pip_pkg::CMD_LOAD, 4, COORD_MIN, COORD_MIN);
		push_word(pip_pkg::CMD_TEST, 0, 0, 0);
		push_word(pip_pkg::CMD_TEST, 0, COORD_MAX, COORD_MAX - 1);
		settle();

		// Full-range triangle: cross products near the widest magnitude.
		set_fence_size(3);
		push_word(pip_pkg::CMD_LOAD, 0, COORD_MIN, COORD_MAX);
		push_word(pip_pkg::CMD_LOAD, 1, COORD_MAX, COORD_MIN);
		push_word(pip_pkg::CMD_LOAD, 2, COORD_MAX, COORD_MAX);
		push_word(pip_pkg::CMD_TEST, 0, 0, 0);
		push_word(pip_pkg::CMD_TEST, 0, 1, 0);
		push_word(pip_pkg::CMD_TEST, 0, -1, 0);
		push_word(pip_pkg::CMD_TEST, 0, 0, 1);
		settle();

		// Degenerate fences of two and one vertex.
		set_fence_size(2);
		push_word(pip_pkg::CMD_TEST, 0, 0, 0);
		settle();
		set_fence_size(1);
		push_word(pip_pkg::CMD_TEST, 0, 0, 0);
		settle();

		// Random phases; the fourth one carries the long receiver hold-off.
		phase_no = 0;
		while (words_sent < TARGET_WORDS) begin
			random_phase(phase_no == 3);
			phase_no++;
		end

		$display("Ran %0d words: %0d point tests (%0d inside) over %0d fence size settings",
			words_sent, board.tests, board.insides, sizes_tried);
		if (board.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/pip_pkg.sv
hw/rtl/pip_vstore.sv
hw/rtl/pip_edge.sv
hw/rtl/point_in_polygon_test.sv
sim/testbench.sv
